### src/bds_pkg.sv
package bds_pkg;

    // Widths of the configuration registers and of the port
    localparam int SRC_REG_BITS  = 13;
    localparam int BAND_REG_BITS = 3;
    localparam int CFG_DATA_BITS = 13;
    localparam int CFG_INDEX_BITS = 2;

    // Row limit of the source raster and position widths
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int ROW_BITS      = 12;
    localparam int COORD_BITS    = 11;
    localparam int BAND_OUT_BITS = 2;

    // Register values after reset
    localparam logic [SRC_REG_BITS-1:0]  WIDTH_RESET  = 13'd4096;
    localparam logic [SRC_REG_BITS-1:0]  HEIGHT_RESET = 13'd4096;
    localparam logic [BAND_REG_BITS-1:0] BANDS_RESET  = 3'd1;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_BAND_COUNT    = 2'd2
    } cfg_reg_t;

    // Stream position of the current sample, as the datapath needs it
    typedef struct packed {
        logic                     col_odd;
        logic                     row_odd;
        logic                     last_col_pair;
        logic                     last_row_pair;
        logic                     last_band;
        logic [COORD_BITS-1:0]    out_col;
        logic [COORD_BITS-1:0]    out_row;
        logic [BAND_OUT_BITS-1:0] band;
    } pos_t;

endpackage

### src/box_downsample_2x2_complex_top.sv
// 2x2 box-mean downsampler for band-interleaved complex raster streams.
//
// Input channel: one complex band sample (sample_re, sample_im) per
// transfer, raster order, bands of a pixel back to back. Output channel:
// one mean per band per 2x2 block, with its output column, row and band,
// and level_done on the last mean of the frame. Odd last row or column
// samples are taken and dropped.
// Configuration: cfg_write with cfg_index 0 (source width), 1 (source
// height) or 2 (band count); any such write restarts the frame. Write
// only while the block is idle.
// Throughput: one sample per cycle while the output is not stalled, set
// by the single pass through one pipeline stage; the line buffer is one
// RAM, one write and one read per cycle.
// Path: the lower right sample of a block is registered in stage 1, and
// its mean in the output register, unless the output register is stalled.
// Reset: frame position to the start, frame 4096 x 4096, one band. The
// line buffer is not cleared; it is always written before its data is used.
// Stall: the output register holds while mean_stall is high; one more
// sample is held in the internal stage, then sample_stall goes high.
module box_downsample_2x2_complex_top #(
    parameter int MAX_WIDTH   = 4096,
    parameter int MAX_BANDS   = 4,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [bds_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [bds_pkg::CFG_DATA_BITS-1:0]       cfg_data,
    input  logic                                    sample_valid,
    output logic                                    sample_stall,
    input  logic signed [SAMPLE_BITS-1:0]           sample_re,
    input  logic signed [SAMPLE_BITS-1:0]           sample_im,
    output logic                                    mean_valid,
    input  logic                                    mean_stall,
    output logic signed [SAMPLE_BITS-1:0]           mean_re,
    output logic signed [SAMPLE_BITS-1:0]           mean_im,
    output logic [bds_pkg::COORD_BITS-1:0]          out_column,
    output logic [bds_pkg::COORD_BITS-1:0]          out_row,
    output logic [bds_pkg::BAND_OUT_BITS-1:0]       band_index,
    output logic                                    level_done
);

    localparam int BAND_BITS  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int LINE_DEPTH = (MAX_WIDTH / 2) * MAX_BANDS;
    localparam int ADDR_BITS  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int PAIR_BITS  = SAMPLE_BITS + 1;
    localparam int SUM_BITS   = SAMPLE_BITS + 2;

    logic                  accept;
    bds_pkg::pos_t         cur_pos;
    logic [ADDR_BITS-1:0]  cur_slot;
    logic [BAND_BITS-1:0]  cur_band;

    // Stage 1: accepted sample and its position
    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_re_reg;
    logic signed [SAMPLE_BITS-1:0] s1_im_reg;
    bds_pkg::pos_t                 s1_pos_reg;
    logic [ADDR_BITS-1:0]          s1_slot_reg;
    logic [BAND_BITS-1:0]          s1_band_reg;
    logic                          s1_adv;
    logic                          s1_produce;

    // Left pixel of the current pair, per band
    logic signed [SAMPLE_BITS-1:0] hold_re_reg [MAX_BANDS];
    logic signed [SAMPLE_BITS-1:0] hold_im_reg [MAX_BANDS];

    // Sums
    logic signed [PAIR_BITS-1:0]   pair_re, pair_im;
    logic signed [PAIR_BITS-1:0]   line_re, line_im;
    logic signed [SUM_BITS-1:0]    total_re, total_im;
    logic [2*PAIR_BITS-1:0]        line_rd_data;
    logic                          line_wr_en;

    // Output register
    logic                                mean_valid_reg;
    logic signed [SAMPLE_BITS-1:0]       mean_re_reg, mean_im_reg;
    logic [bds_pkg::COORD_BITS-1:0]      out_column_reg, out_row_reg;
    logic [bds_pkg::BAND_OUT_BITS-1:0]   band_index_reg;
    logic                                level_done_reg;

    assign s1_adv       = !mean_valid_reg || !mean_stall;
    assign sample_stall = s1_valid_reg && !s1_adv;
    assign accept       = sample_valid && !sample_stall;
    assign s1_produce   = s1_valid_reg && s1_pos_reg.col_odd && s1_pos_reg.row_odd;

    bds_cursor #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BANDS (MAX_BANDS)
    ) u_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .pos       (cur_pos),
        .slot      (cur_slot),
        .band      (cur_band)
    );

    // Line buffer of upper-row pair sums, imaginary in the high half
    assign line_wr_en = s1_valid_reg && s1_adv && s1_pos_reg.col_odd && !s1_pos_reg.row_odd;

    bds_ram #(
        .WIDTH (2 * PAIR_BITS),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk     (clk),
        .wr_en   (line_wr_en),
        .wr_addr (s1_slot_reg),
        .wr_data ({pair_im, pair_re}),
        .rd_en   (accept),
        .rd_addr (cur_slot),
        .rd_data (line_rd_data)
    );

    // Track stage 1 occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    // Load stage 1 and hold the left pixel of a pair on each transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_re_reg   <= sample_re;
            s1_im_reg   <= sample_im;
            s1_pos_reg  <= cur_pos;
            s1_slot_reg <= cur_slot;
            s1_band_reg <= cur_band;
            if (!cur_pos.col_odd)
            begin
                hold_re_reg[cur_band] <= sample_re;
                hold_im_reg[cur_band] <= sample_im;
            end
        end
    end

    // Add the pair, then the upper pair, and divide by four
    assign pair_re  = PAIR_BITS'(hold_re_reg[s1_band_reg]) + PAIR_BITS'(s1_re_reg);
    assign pair_im  = PAIR_BITS'(hold_im_reg[s1_band_reg]) + PAIR_BITS'(s1_im_reg);
    assign line_re  = $signed(line_rd_data[PAIR_BITS-1:0]);
    assign line_im  = $signed(line_rd_data[2*PAIR_BITS-1:PAIR_BITS]);
    assign total_re = SUM_BITS'(line_re) + SUM_BITS'(pair_re);
    assign total_im = SUM_BITS'(line_im) + SUM_BITS'(pair_im);

    // Track output occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mean_valid_reg <= 1'b0;
        else if (s1_adv)
            mean_valid_reg <= s1_produce;
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_produce)
        begin
            mean_re_reg    <= total_re[SUM_BITS-1:2];
            mean_im_reg    <= total_im[SUM_BITS-1:2];
            out_column_reg <= s1_pos_reg.out_col;
            out_row_reg    <= s1_pos_reg.out_row;
            band_index_reg <= s1_pos_reg.band;
            level_done_reg <= s1_pos_reg.last_col_pair && s1_pos_reg.last_row_pair &&
                              s1_pos_reg.last_band;
        end
    end

    assign mean_valid = mean_valid_reg;
    assign mean_re    = mean_re_reg;
    assign mean_im    = mean_im_reg;
    assign out_column = out_column_reg;
    assign out_row    = out_row_reg;
    assign band_index = band_index_reg;
    assign level_done = level_done_reg;

endmodule

### src/bds_ram.sv
module bds_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 8192,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one entry, read one entry into the output register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/bds_cursor.sv
module bds_cursor #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_BANDS = 4,
    localparam int BAND_BITS  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1,
    localparam int LINE_DEPTH = (MAX_WIDTH / 2) * MAX_BANDS,
    localparam int ADDR_BITS  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [bds_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [bds_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                advance,
    output bds_pkg::pos_t                       pos,
    output logic [ADDR_BITS-1:0]                slot,
    output logic [BAND_BITS-1:0]                band
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int W_BITS   = $clog2(MAX_WIDTH + 1);
    localparam int NB_BITS  = $clog2(MAX_BANDS + 1);

    logic [bds_pkg::SRC_REG_BITS-1:0]  width_reg;
    logic [bds_pkg::SRC_REG_BITS-1:0]  height_reg;
    logic [bds_pkg::BAND_REG_BITS-1:0] bands_reg;
    logic [COL_BITS-1:0]               col_reg,  col_next;
    logic [bds_pkg::ROW_BITS-1:0]      row_reg,  row_next;
    logic [BAND_BITS-1:0]              band_reg, band_next;

    logic [W_BITS-1:0]                 w;
    logic [bds_pkg::SRC_REG_BITS-1:0]  h;
    logic [NB_BITS-1:0]                nb;
    logic [BAND_BITS-1:0]              b_eff;
    logic [31:0]                       band_plus;
    logic [31:0]                       col_plus;
    logic [31:0]                       row_plus;
    logic [31:0]                       slot_wide;
    logic                              cfg_hit;

    // Clamp the frame registers to their legal ranges
    always_comb
    begin
        if (width_reg < 13'd2)
            w = W_BITS'(2);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w = W_BITS'(MAX_WIDTH);
        else
            w = W_BITS'(width_reg);

        if (height_reg < 13'd2)
            h = 13'd2;
        else if (32'(height_reg) > 32'(bds_pkg::HEIGHT_LIMIT))
            h = bds_pkg::SRC_REG_BITS'(bds_pkg::HEIGHT_LIMIT);
        else
            h = height_reg;

        if (bands_reg == 3'd0)
            nb = NB_BITS'(1);
        else if (32'(bands_reg) > 32'(MAX_BANDS))
            nb = NB_BITS'(MAX_BANDS);
        else
            nb = NB_BITS'(bands_reg);
    end

    assign b_eff     = (32'(band_reg) >= 32'(nb)) ? '0 : band_reg;
    assign band_plus = 32'(b_eff) + 32'd1;
    assign col_plus  = 32'(col_reg) + 32'd1;
    assign row_plus  = 32'(row_reg) + 32'd1;

    // Advance band, then column, then row; wrap at frame end
    always_comb
    begin
        band_next = band_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (advance)
        begin
            if (band_plus >= 32'(nb))
            begin
                band_next = '0;
                if (col_plus >= 32'(w))
                begin
                    col_next = '0;
                    if (row_plus >= 32'(h))
                        row_next = '0;
                    else
                        row_next = bds_pkg::ROW_BITS'(row_plus);
                end
                else
                begin
                    col_next = COL_BITS'(col_plus);
                end
            end
            else
            begin
                band_next = BAND_BITS'(band_plus);
            end
        end
    end

    assign cfg_hit = cfg_write &&
                     (cfg_index == bds_pkg::REG_SOURCE_WIDTH ||
                      cfg_index == bds_pkg::REG_SOURCE_HEIGHT ||
                      cfg_index == bds_pkg::REG_BAND_COUNT);

    // Take register writes; a write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bds_pkg::WIDTH_RESET;
            height_reg <= bds_pkg::HEIGHT_RESET;
            bands_reg  <= bds_pkg::BANDS_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            band_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    bds_pkg::REG_SOURCE_WIDTH:  width_reg  <= cfg_data;
                    bds_pkg::REG_SOURCE_HEIGHT: height_reg <= cfg_data;
                    bds_pkg::REG_BAND_COUNT:    bands_reg  <= cfg_data[bds_pkg::BAND_REG_BITS-1:0];
                    default:                    ;
                endcase
            end
            if (cfg_hit)
            begin
                col_reg  <= '0;
                row_reg  <= '0;
                band_reg <= '0;
            end
            else
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                band_reg <= band_next;
            end
        end
    end

    // Describe the current position for the datapath
    assign slot_wide = 32'(col_reg >> 1) * 32'(MAX_BANDS) + 32'(b_eff);
    assign slot      = slot_wide[ADDR_BITS-1:0];
    assign band      = b_eff;

    always_comb
    begin
        pos.col_odd       = col_reg[0];
        pos.row_odd       = row_reg[0];
        pos.last_col_pair = (32'(col_reg >> 1) == 32'(w >> 1) - 32'd1);
        pos.last_row_pair = (32'(row_reg >> 1) == 32'(h >> 1) - 32'd1);
        pos.last_band     = (32'(b_eff) == 32'(nb) - 32'd1);
        pos.out_col       = bds_pkg::COORD_BITS'(col_reg >> 1);
        pos.out_row       = bds_pkg::COORD_BITS'(row_reg >> 1);
        pos.band          = bds_pkg::BAND_OUT_BITS'(b_eff);
    end

endmodule

### src/bds_checker.sv
module bds_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 sample_valid,
    input logic                                 sample_stall,
    input logic                                 mean_valid,
    input logic                                 mean_stall,
    input logic signed [SAMPLE_BITS-1:0]        mean_re,
    input logic signed [SAMPLE_BITS-1:0]        mean_im,
    input logic [bds_pkg::COORD_BITS-1:0]       out_column,
    input logic [bds_pkg::COORD_BITS-1:0]       out_row,
    input logic [bds_pkg::BAND_OUT_BITS-1:0]    band_index,
    input logic                                 level_done
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mean_valid && mean_stall |=> mean_valid && $stable(mean_re) && $stable(mean_im) &&
        $stable(out_column) && $stable(out_row) && $stable(band_index) &&
        $stable(level_done))
        else $error("stalled result changed");

    // Stall the input only while the output holds a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> mean_valid && mean_stall)
        else $error("input stalled with room in the pipeline");

    // Leave reset with an empty output
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !mean_valid)
        else $error("result present right after reset");

    // A fresh result rises only with a sample transfer behind it in stage 1
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mean_valid) |-> $past(sample_valid && !sample_stall, 2))
        else $error("result without a matching sample transfer");

endmodule

bind box_downsample_2x2_complex_top bds_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (.*);
